// ----- sv/infix_to_postfix_converter_macros.svh -----
// Assertion macros shared by the converter RTL.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
`define ITP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("itp: assertion failed");
`define ITP_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("itp: forbidden condition seen");
`else
`define ITP_ASSERT(lbl, clk, rst, prop)
`define ITP_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ----- sv/itp_pkg.sv -----
package itp_pkg;

  localparam int STACK_DEPTH_DEFAULT = 32;
  localparam int QUEUE_DEPTH = 4;

  // input token kinds
  localparam logic [2:0] TK_NUMBER   = 3'd0;
  localparam logic [2:0] TK_FUNCTION = 3'd1;
  localparam logic [2:0] TK_OPEN     = 3'd2;
  localparam logic [2:0] TK_CLOSE    = 3'd3;
  localparam logic [2:0] TK_OPERATOR = 3'd4;
  localparam logic [2:0] TK_END      = 3'd5;

  // operator codes
  localparam logic [2:0] OP_PLUS   = 3'd0;
  localparam logic [2:0] OP_MINUS  = 3'd1;
  localparam logic [2:0] OP_MODULO = 3'd4;
  localparam logic [2:0] OP_POWER  = 3'd5;

  // stack entry codes: 0..5 operator, 6 paren, functions 8..15 (bit 3 set)
  localparam logic [3:0] ENTRY_PAREN = 4'd6;

  typedef enum logic [1:0] {
    KIND_NUMBER   = 2'd0,
    KIND_OPERATOR = 2'd1,
    KIND_FUNCTION = 2'd2,
    KIND_OVERFLOW = 2'd3
  } out_kind_t;

  typedef enum logic [2:0] {
    CMD_NUMBER,
    CMD_PUSH,
    CMD_CLOSE,
    CMD_OPER,
    CMD_END
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_TOP,
    S_FINISH
  } back_state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  entry;
    logic [31:0] num;
  } qitem_t;

  typedef struct packed {
    out_kind_t   kind;
    logic [2:0]  op;
    logic [2:0]  fn;
    logic [31:0] num;
  } res_t;

  function automatic logic [1:0] prec_of(input logic [3:0] entry);
    logic [1:0] p;
    if (entry <= {1'b0, OP_MINUS}) p = 2'd1;
    else if (entry <= {1'b0, OP_MODULO}) p = 2'd2;
    else if (entry == {1'b0, OP_POWER}) p = 2'd3;
    else p = 2'd0;
    return p;
  endfunction

  function automatic res_t entry_result(input logic [3:0] entry);
    res_t r;
    r = '0;
    if (entry[3]) begin
      r.kind = KIND_FUNCTION;
      r.fn   = entry[2:0];
    end else begin
      r.kind = KIND_OPERATOR;
      r.op   = entry[2:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/itp_in_if.sv -----
interface itp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [2:0]  operator_code;
  logic [2:0]  function_code;
  logic [31:0] number_handle;

  modport source (
    output valid, token_kind, operator_code, function_code, number_handle,
    input  ready
  );
  modport sink (
    input  valid, token_kind, operator_code, function_code, number_handle,
    output ready
  );
endinterface

// ----- sv/itp_out_if.sv -----
interface itp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [2:0]  out_operator;
  logic [2:0]  out_function;
  logic [31:0] out_number;
  logic        last_of_run;

  modport source (
    output valid, out_kind, out_operator, out_function, out_number, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, out_kind, out_operator, out_function, out_number, last_of_run,
    output ready
  );
endinterface

// ----- sv/infix_to_postfix_converter.sv -----
// Channel   Dir  Fields
// tokens    in   token_kind, operator_code, function_code, number_handle
// postfix   out  out_kind, out_operator, out_function, out_number, last_of_run
//
// A token goes through S_IDLE, S_DISPATCH, one S_TOP step per stack entry it
// examines, and S_FINISH; one registered stack read per cycle when not stalled.
// Reset is synchronous: it clears the stack count and queue; stack contents
// are not cleared and need no sweep.
// A 4-beat queue lets tokens keep arriving while postfix is stalled.
// Unrecognized tokens are taken and dropped by the front end.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  itp_in_if.sink    tokens,
  itp_out_if.source postfix
);
  import itp_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  qitem_t q_wr_item;
  qitem_t q_rd_item;

  itp_front u_front (
    .tokens (tokens),
    .q_full (q_full),
    .push   (q_push),
    .item   (q_wr_item)
  );

  itp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .q_valid (q_valid),
    .pop     (q_pop),
    .rd_item (q_rd_item)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_rd_item),
    .q_pop   (q_pop),
    .postfix (postfix)
  );

endmodule

// ----- sv/itp_front.sv -----
module itp_front (
  itp_in_if.sink         tokens,
  input  logic           q_full,
  output logic           push,
  output itp_pkg::qitem_t item
);
  import itp_pkg::*;

  logic keep;

  always_comb begin
    item.cmd   = CMD_NUMBER;
    item.entry = '0;
    item.num   = tokens.number_handle;
    keep       = 1'b0;
    unique case (tokens.token_kind)
      TK_NUMBER: begin
        keep = 1'b1;
      end
      TK_FUNCTION: begin
        keep       = 1'b1;
        item.cmd   = CMD_PUSH;
        item.entry = {1'b1, tokens.function_code};
      end
      TK_OPEN: begin
        keep       = 1'b1;
        item.cmd   = CMD_PUSH;
        item.entry = ENTRY_PAREN;
      end
      TK_CLOSE: begin
        keep     = 1'b1;
        item.cmd = CMD_CLOSE;
      end
      TK_OPERATOR: begin
        keep       = (tokens.operator_code <= OP_POWER);
        item.cmd   = CMD_OPER;
        item.entry = {1'b0, tokens.operator_code};
      end
      TK_END: begin
        keep     = 1'b1;
        item.cmd = CMD_END;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // ignored tokens are taken and dropped here
  assign tokens.ready = !q_full;
  assign push         = tokens.valid && !q_full && keep;

endmodule

// ----- sv/itp_queue.sv -----
`include "infix_to_postfix_converter_macros.svh"

module itp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  itp_pkg::qitem_t wr_item,
  output logic            full,
  output logic            q_valid,
  input  logic            pop,
  output itp_pkg::qitem_t rd_item
);
  import itp_pkg::*;

  localparam int QAW = $clog2(QUEUE_DEPTH);

  qitem_t          slots [QUEUE_DEPTH];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QAW:0]    fill;

  assign full    = (fill == (QAW+1)'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop) rd_ptr <= rd_ptr + QAW'(1);
      fill <= fill + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_item;
  end

  `ITP_NEVER(a_fill_range, clk, rst, fill > (QAW+1)'(QUEUE_DEPTH))
  `ITP_NEVER(a_push_full, clk, rst, push && full)
  `ITP_NEVER(a_pop_empty, clk, rst, pop && !q_valid)

endmodule

// ----- sv/itp_back.sv -----
`include "infix_to_postfix_converter_macros.svh"

module itp_back #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  itp_pkg::qitem_t q_item,
  output logic            q_pop,
  itp_out_if.source       postfix
);
  import itp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);

  typedef struct packed {
    logic emit;
    res_t res;
    logic pop;
    logic push;
    logic rd_en;
    logic done;
    logic set_after;
  } act_t;

  back_state_t    state;
  back_state_t    state_next;
  qitem_t         cur;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic           after_paren;
  logic [3:0]     stack_mem [STACK_DEPTH];
  logic [3:0]     rd;
  res_t           pend;
  logic           pend_valid;
  res_t           out_res;
  logic           out_last;
  logic           out_valid;

  act_t           act;
  logic           go;
  logic           out_free;
  logic           slot_ok;
  logic           fin_flush;
  logic           load_out;
  logic           full;
  logic           count_one;
  logic           t_paren;
  logic [CW-1:0]  cm1;
  logic [CW-1:0]  cm2;
  logic [IW-1:0]  rd_addr;
  logic [IW-1:0]  wr_addr;

  assign out_free  = !out_valid || postfix.ready;
  assign slot_ok   = !pend_valid || out_free;
  assign full      = (count == CW'(STACK_DEPTH));
  assign count_one = (count == CW'(1));
  assign t_paren   = (rd == ENTRY_PAREN);
  assign cm1       = count - CW'(1);
  assign cm2       = count - CW'(2);

  // action decode
  always_comb begin
    act = '0;
    unique case (state)
      S_DISPATCH: begin
        unique case (cur.cmd)
          CMD_NUMBER: begin
            act.emit     = 1'b1;
            act.res.kind = KIND_NUMBER;
            act.res.num  = cur.num;
            act.done     = 1'b1;
          end
          CMD_PUSH: begin
            if (full) begin
              act.emit     = 1'b1;
              act.res.kind = KIND_OVERFLOW;
            end else begin
              act.push = 1'b1;
            end
            act.done = 1'b1;
          end
          CMD_OPER: begin
            if (count == '0) begin
              act.push = 1'b1;
              act.done = 1'b1;
            end else begin
              act.rd_en = 1'b1;
            end
          end
          default: begin
            if (count == '0) act.done = 1'b1;
            else act.rd_en = 1'b1;
          end
        endcase
      end
      S_TOP: begin
        unique case (cur.cmd)
          CMD_CLOSE: begin
            if (after_paren) begin
              if (rd[3]) begin
                act.emit = 1'b1;
                act.res  = entry_result(rd);
                act.pop  = 1'b1;
              end
              act.done = 1'b1;
            end else begin
              act.pop = 1'b1;
              if (!t_paren) begin
                act.emit = 1'b1;
                act.res  = entry_result(rd);
              end else begin
                act.set_after = !count_one;
              end
              act.done  = count_one;
              act.rd_en = !count_one;
            end
          end
          CMD_OPER: begin
            if (t_paren || (prec_of(rd) < prec_of(cur.entry))) begin
              if (full) begin
                act.emit     = 1'b1;
                act.res.kind = KIND_OVERFLOW;
              end else begin
                act.push = 1'b1;
              end
              act.done = 1'b1;
            end else begin
              act.emit  = 1'b1;
              act.res   = entry_result(rd);
              act.pop   = 1'b1;
              // last entry popped: the operator takes its place
              act.push  = count_one;
              act.done  = count_one;
              act.rd_en = !count_one;
            end
          end
          CMD_END: begin
            act.emit  = !t_paren;
            act.res   = entry_result(rd);
            act.pop   = 1'b1;
            act.done  = count_one;
            act.rd_en = !count_one;
          end
          default: begin
            act.done = 1'b1;
          end
        endcase
      end
      default: begin
        act = '0;
      end
    endcase
  end

  assign go        = !(act.emit && !slot_ok);
  assign fin_flush = (state == S_FINISH) && pend_valid && out_free;
  assign load_out  = (go && act.emit && pend_valid) || fin_flush;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign count_next = count + CW'(act.push) - CW'(act.pop);
  assign rd_addr   = (state == S_DISPATCH) ? cm1[IW-1:0] : cm2[IW-1:0];
  assign wr_addr   = act.pop ? cm1[IW-1:0] : count[IW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH, S_TOP: begin
        if (go) state_next = act.done ? S_FINISH : S_TOP;
      end
      S_FINISH: begin
        if (slot_ok) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      after_paren <= 1'b0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (go) count <= count_next;
      if (q_pop) after_paren <= 1'b0;
      else if (go && act.set_after) after_paren <= 1'b1;
      if (go && act.emit) pend_valid <= 1'b1;
      else if (fin_flush) pend_valid <= 1'b0;
      if (load_out) out_valid <= 1'b1;
      else if (postfix.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_item;
    if (go && act.emit) pend <= act.res;
    if (load_out) begin
      out_res  <= pend;
      out_last <= fin_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (go && act.push) stack_mem[wr_addr] <= cur.entry;
    if (go && act.rd_en) rd <= stack_mem[rd_addr];
  end

  assign postfix.valid        = out_valid;
  assign postfix.out_kind     = out_res.kind;
  assign postfix.out_operator = out_res.op;
  assign postfix.out_function = out_res.fn;
  assign postfix.out_number   = out_res.num;
  assign postfix.last_of_run  = out_last;

  `ITP_NEVER(a_count_range, clk, rst, count > CW'(STACK_DEPTH))
  `ITP_ASSERT(a_count_step, clk, rst, 1'b1 |=> (count == $past(count) || count == $past(count) + CW'(1) || count == $past(count) - CW'(1)))
  `ITP_NEVER(a_idle_flushed, clk, rst, state == S_IDLE && pend_valid)
  `ITP_NEVER(a_after_close, clk, rst, after_paren && cur.cmd != CMD_CLOSE)

endmodule
